// ----- rtl/skt_pkg.sv -----
// ----------------------------------------------------------------------------
// skt_pkg
// Shared types and constants for the sorted key table: transaction payloads
// and the command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int KEY_W     = 32;
  localparam int VAL_W     = 16;
  localparam int ENTRIES_W = 7;
  localparam int ENTRY_W   = KEY_W + VAL_W;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_ADD    = 1'b1;

  typedef struct packed {
    logic             op;
    logic [KEY_W-1:0] code;
    logic [VAL_W-1:0] desc_handle;
  } in_t;

  typedef struct packed {
    logic                 found;
    logic [VAL_W-1:0]     value;
    logic                 full_error;
    logic [ENTRIES_W-1:0] entries;
  } out_t;

  typedef struct packed {
    logic start;
    logic rd_mid;
    logic cmp;
    logic decide;
    logic wr_update;
    logic shift_init;
    logic shift;
    logic wr_insert;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic range_empty;
    logic key_eq;
    logic op_add;
    logic hit;
    logic full;
    logic shift_done;
  } status_t;

endpackage

// ----- rtl/sorted_key_table_lookup_core.sv -----
// ----------------------------------------------------------------------------
// sorted_key_table_lookup_core
// Sorted key table with binary-search lookup and sorted insert.
//
// Input channel (in_valid/in_ready/in_data): one transaction is a lookup
// (op = 0) or an add/update (op = 1) of a 32-bit key with a 16-bit handle.
// Result channel (out_valid/out_ready/out_data): exactly one result per
// input transaction, in order: found, value, full_error, entries.
// One transaction is worked at a time. Each search probe reads the table
// memory, which has one read port and one write port, and then compares
// the key; an insert then moves the (count - pos) entries above the
// insertion point up by one, one entry per cycle, before it writes the new
// entry and the count grows by one.
// The result sits in an output register: while it waits for out_ready the
// next transaction is already accepted and searched, and it stalls only
// when its own result is ready and the register is still full.
// Reset (rst_n low, synchronous) empties the table; the key memory itself
// is not cleared, entries above the count are never used.
// ----------------------------------------------------------------------------
module sorted_key_table_lookup_core #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  skt_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output skt_pkg::out_t out_data
);

  skt_pkg::cmd_t    cmd;
  skt_pkg::status_t st;

  skt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  skt_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .st       (st),
    .out_data (out_data)
  );

endmodule

// ----- rtl/skt_dpath.sv -----
// ----------------------------------------------------------------------------
// skt_dpath
// Table memory, binary search bounds, shift pointers, entry count and the
// result register.
// ----------------------------------------------------------------------------
module skt_dpath #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  skt_pkg::in_t     in_data,
  input  skt_pkg::cmd_t    cmd,
  output skt_pkg::status_t st,
  output skt_pkg::out_t    out_data
);

  localparam int IW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int EntW = skt_pkg::ENTRIES_W;
  localparam int EW   = skt_pkg::ENTRY_W;
  localparam int KW   = skt_pkg::KEY_W;
  localparam int VW   = skt_pkg::VAL_W;

  logic [EW-1:0] mem [TABLE_DEPTH];
  logic [EW-1:0] rdata_r;

  skt_pkg::in_t  item_r;
  skt_pkg::out_t out_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] lo_r;
  logic [CW-1:0] hi_r;
  logic [CW-1:0] mid_r;
  logic [CW-1:0] dst_r;
  logic [CW-1:0] n_r;
  logic [IW-1:0] wa_r;
  logic          wpend_r;
  logic          hit_r;
  logic          ferr_r;
  logic [VW-1:0] val_r;

  logic [CW-1:0] mid_c;
  logic [CW-1:0] dst_m1;
  logic [IW-1:0] raddr;
  logic [IW-1:0] waddr;
  logic [EW-1:0] wdata;
  logic          we;
  logic [KW-1:0] rkey;

  assign mid_c  = lo_r + ((hi_r - lo_r) >> 1);
  assign dst_m1 = dst_r - CW'(1);
  assign raddr  = cmd.shift ? dst_m1[IW-1:0] : mid_c[IW-1:0];
  assign rkey   = rdata_r[EW-1:VW];

  always_comb begin
    we    = 1'b0;
    waddr = lo_r[IW-1:0];
    wdata = {item_r.code, item_r.desc_handle};
    if (cmd.wr_update || cmd.wr_insert) begin
      we = 1'b1;
    end else if (cmd.shift && wpend_r) begin
      we    = 1'b1;
      waddr = wa_r;
      wdata = rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      wpend_r <= 1'b0;
      hit_r   <= 1'b0;
    end else begin
      if (cmd.start) begin
        item_r <= in_data;
        lo_r   <= '0;
        hi_r   <= count_r;
        hit_r  <= 1'b0;
      end
      if (cmd.rd_mid) begin
        mid_r <= mid_c;
      end
      if (cmd.cmp) begin
        if (item_r.code < rkey) begin
          hi_r <= mid_r;
        end else if (item_r.code > rkey) begin
          lo_r <= mid_r + CW'(1);
        end else begin
          lo_r  <= mid_r;
          hit_r <= 1'b1;
          val_r <= rdata_r[VW-1:0];
        end
      end
      if (cmd.decide) begin
        ferr_r <= (item_r.op == skt_pkg::OP_ADD) && !hit_r
                  && (count_r == CW'(TABLE_DEPTH));
      end
      if (cmd.shift_init) begin
        dst_r   <= count_r;
        n_r     <= count_r - lo_r;
        wpend_r <= 1'b0;
      end else if (cmd.shift) begin
        if (n_r != '0) begin
          n_r     <= n_r - CW'(1);
          dst_r   <= dst_m1;
          wa_r    <= dst_r[IW-1:0];
          wpend_r <= 1'b1;
        end else begin
          wpend_r <= 1'b0;
        end
      end
      if (cmd.wr_insert) begin
        count_r <= count_r + CW'(1);
      end
      if (cmd.load_out) begin
        out_r.found      <= hit_r;
        out_r.value      <= ((item_r.op == skt_pkg::OP_LOOKUP) && hit_r) ? val_r : '0;
        out_r.full_error <= ferr_r;
        out_r.entries    <= EntW'(count_r);
      end
    end
  end

  assign st.range_empty = (lo_r >= hi_r);
  assign st.key_eq      = (item_r.code == rkey);
  assign st.op_add      = (item_r.op == skt_pkg::OP_ADD);
  assign st.hit         = hit_r;
  assign st.full        = (count_r == CW'(TABLE_DEPTH));
  assign st.shift_done  = (n_r == '0) && !wpend_r;

  assign out_data = out_r;

endmodule

// ----- rtl/skt_ctrl.sv -----
// ----------------------------------------------------------------------------
// skt_ctrl
// Sequencer for search, update, shift and insert; owns the handshakes.
// ----------------------------------------------------------------------------
module skt_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  skt_pkg::status_t st,
  output skt_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH,
    S_CMP,
    S_DEC,
    S_SHIFT,
    S_INS,
    S_RES
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_SRCH;
        end
      end
      S_SRCH: begin
        if (st.range_empty) begin
          state_nxt = S_DEC;
        end else begin
          cmd.rd_mid = 1'b1;
          state_nxt  = S_CMP;
        end
      end
      S_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = st.key_eq ? S_DEC : S_SRCH;
      end
      S_DEC: begin
        cmd.decide = 1'b1;
        if (!st.op_add || st.full && !st.hit) begin
          state_nxt = S_RES;
        end else if (st.hit) begin
          cmd.wr_update = 1'b1;
          state_nxt     = S_RES;
        end else begin
          cmd.shift_init = 1'b1;
          state_nxt      = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (st.shift_done) begin
          state_nxt = S_INS;
        end
      end
      S_INS: begin
        cmd.wr_insert = 1'b1;
        state_nxt     = S_RES;
      end
      S_RES: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- tb/sorted_key_table_lookup_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_key_table_lookup_core_tb
// Drives lookup and add/update transactions into the sorted key table and
// checks every result against a shadow table kept in the testbench. A short
// directed run covers the empty table, the key extremes, front, middle and
// end inserts, updates and misses. It is followed by random traffic that
// mostly reuses known keys and their neighbours and fills the table until
// new keys are refused. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module sorted_key_table_lookup_core_tb;

  localparam int KEY_W        = skt_pkg::KEY_W;
  localparam int VAL_W        = skt_pkg::VAL_W;
  localparam int ENTRIES_W    = skt_pkg::ENTRIES_W;
  localparam int TABLE_DEPTH  = 64;
  localparam int RANDOM_ITEMS = 950;
  localparam int DRAIN_CYCLES = 200;

  logic          clk       = 1'b0;
  logic          rst_n     = 1'b0;
  logic          in_valid  = 1'b0;
  logic          out_ready = 1'b0;
  skt_pkg::in_t  in_data   = '0;
  logic          in_ready;
  logic          out_valid;
  skt_pkg::out_t out_data;

  sorted_key_table_lookup_core #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow copy of the table
  logic [KEY_W-1:0] shadow_keys [TABLE_DEPTH];
  logic [VAL_W-1:0] shadow_vals [TABLE_DEPTH];
  int               shadow_count = 0;

  skt_pkg::in_t     pending_items [$];
  skt_pkg::out_t    expected_results [$];
  logic [KEY_W-1:0] key_pool [$];

  int            accepted_count = 0;
  int            fail_count     = 0;
  int            gap_left       = 0;
  int            stall_left     = 0;
  bit            in_burst       = 1'b0;
  bit            out_burst      = 1'b0;
  skt_pkg::out_t want;

  function automatic skt_pkg::out_t table_apply(skt_pkg::in_t item);
    skt_pkg::out_t res;
    int   lo;
    int   hi;
    int   mid;
    int   pos;
    bit   hit;
    lo  = 0;
    hi  = shadow_count;
    pos = 0;
    hit = 1'b0;
    while (lo < hi && !hit) begin
      mid = lo + (hi - lo) / 2;
      if (item.code < shadow_keys[mid]) begin
        hi = mid;
      end else if (item.code > shadow_keys[mid]) begin
        lo = mid + 1;
      end else begin
        hit = 1'b1;
        pos = mid;
      end
    end
    if (!hit) pos = lo;
    res       = '0;
    res.found = hit;
    if (item.op == skt_pkg::OP_LOOKUP) begin
      if (hit) res.value = shadow_vals[pos];
    end else if (hit) begin
      shadow_vals[pos] = item.desc_handle;
    end else if (shadow_count >= TABLE_DEPTH) begin
      res.full_error = 1'b1;
    end else begin
      for (int i = shadow_count; i > pos; i--) begin
        shadow_keys[i] = shadow_keys[i-1];
        shadow_vals[i] = shadow_vals[i-1];
      end
      shadow_keys[pos] = item.code;
      shadow_vals[pos] = item.desc_handle;
      shadow_count++;
    end
    res.entries = ENTRIES_W'(shadow_count);
    return res;
  endfunction

  task automatic queue_item(logic op, logic [KEY_W-1:0] code, logic [VAL_W-1:0] handle);
    skt_pkg::in_t item;
    item.op          = op;
    item.code        = code;
    item.desc_handle = handle;
    pending_items.push_back(item);
    if (op == skt_pkg::OP_ADD) key_pool.push_back(code);
  endtask

  task automatic report_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("mismatch: %s", msg);
  endtask

  function automatic int draw_wait(bit burst);
    return burst ? 0 : $urandom_range(0, 10);
  endfunction

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (in_valid && in_ready) begin
      expected_results.push_back(table_apply(in_data));
      accepted_count <= accepted_count + 1;
      if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
      gap_left <= draw_wait(in_burst);
      if (draw_wait(in_burst) == 0 && in_burst && pending_items.size() != 0) begin
        in_data <= pending_items.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end else if (!in_valid) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_items.size() != 0) begin
        in_data  <= pending_items.pop_front();
        in_valid <= 1'b1;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_failure($sformatf("result %p with no transaction outstanding", out_data));
      end else begin
        want = expected_results.pop_front();
        if (out_data.found !== want.found)
          report_failure($sformatf("found exp %0b got %0b", want.found, out_data.found));
        if (out_data.value !== want.value)
          report_failure($sformatf("value exp %h got %h", want.value, out_data.value));
        if (out_data.full_error !== want.full_error)
          report_failure($sformatf("full_error exp %0b got %0b",
                                   want.full_error, out_data.full_error));
        if (out_data.entries !== want.entries)
          report_failure($sformatf("entries exp %0d got %0d", want.entries, out_data.entries));
      end
      if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
      stall_left <= draw_wait(out_burst);
      if (out_burst) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
      end
    end else if (!out_ready) begin
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int               total;
    int               sel;
    logic [KEY_W-1:0] code;

    // directed: empty table, extremes, front/middle/end inserts, updates, misses
    queue_item(skt_pkg::OP_LOOKUP, 32'h0000_0000, 16'h0000);
    queue_item(skt_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 16'hFFFF);
    queue_item(skt_pkg::OP_ADD,    32'h8000_0000, 16'h1234);
    queue_item(skt_pkg::OP_ADD,    32'h0000_0000, 16'hFFFF);
    queue_item(skt_pkg::OP_ADD,    32'hFFFF_FFFF, 16'h0000);
    queue_item(skt_pkg::OP_LOOKUP, 32'h0000_0000, 16'h0000);
    queue_item(skt_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 16'h5A5A);
    queue_item(skt_pkg::OP_LOOKUP, 32'h7FFF_FFFF, 16'h0000);
    queue_item(skt_pkg::OP_ADD,    32'h0000_0000, 16'h0001);
    queue_item(skt_pkg::OP_LOOKUP, 32'h0000_0000, 16'h0000);
    queue_item(skt_pkg::OP_ADD,    32'h7FFF_FFFF, 16'hAAAA);
    queue_item(skt_pkg::OP_ADD,    32'h8000_0001, 16'h5555);
    queue_item(skt_pkg::OP_LOOKUP, 32'h8000_0000, 16'h0000);
    queue_item(skt_pkg::OP_LOOKUP, 32'h8000_0001, 16'h0000);
    queue_item(skt_pkg::OP_ADD,    32'h8000_0000, 16'hFFFF);
    queue_item(skt_pkg::OP_LOOKUP, 32'h8000_0000, 16'h0000);
    queue_item(skt_pkg::OP_LOOKUP, 32'hFFFF_FFFE, 16'h0000);
    queue_item(skt_pkg::OP_LOOKUP, 32'h0000_0001, 16'h0000);
    queue_item(skt_pkg::OP_ADD,    32'h0000_0001, 16'h8001);
    queue_item(skt_pkg::OP_LOOKUP, 32'h0000_0001, 16'h0000);

    // random: mostly known keys and their neighbours, fills the table to full
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        code = key_pool[$urandom_range(0, key_pool.size() - 1)];
      end else if (sel < 55) begin
        code = key_pool[$urandom_range(0, key_pool.size() - 1)];
        code = $urandom_range(0, 1) ? code + 1 : code - 1;
      end else if (sel < 62) begin
        case ($urandom_range(0, 3))
          0: code = 32'h0000_0000;
          1: code = 32'hFFFF_FFFF;
          2: code = 32'h7FFF_FFFF;
          default: code = 32'h8000_0000;
        endcase
      end else begin
        code = $urandom();
      end
      queue_item($urandom_range(0, 1) ? skt_pkg::OP_ADD : skt_pkg::OP_LOOKUP, code,
                 VAL_W'($urandom_range(0, 65535)));
    end
    total = pending_items.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_count < total || expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      report_failure($sformatf("%0d results never arrived", expected_results.size()));

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- sorted_key_table_lookup_core.f -----
rtl/skt_pkg.sv
rtl/skt_dpath.sv
rtl/skt_ctrl.sv
rtl/sorted_key_table_lookup_core.sv
tb/sorted_key_table_lookup_core_tb.sv
